[rtl/pfm_pkg.sv]
// Shared constants, types and controller states for the polynomial fit scorer.
package pfm_pkg;

    localparam int DEF_MAX_TERMS  = 7;
    localparam int DEF_MAX_POINTS = 65536;

    localparam int NUM_COEFFS = 7;
    localparam int COEFF_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int EST_W      = 40;
    localparam int PROD_W     = EST_W + COEFF_W;
    localparam int ADD_W      = PROD_W - FRAC_W + 1;
    localparam int DIFF_W     = EST_W + 1;
    localparam int SQ_IN_W    = 32;
    localparam int SUM_W      = 64;
    localparam int OUT_W      = 48;
    localparam int TC_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int S_DATA_W   = 2 * COEFF_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // Register index of the term count; coefficients sit below it
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = CFG_IDX_W'(NUM_COEFFS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIFF,
        ST_SQ,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } pfm_state_t;

    typedef struct packed {
        logic load_item;
        logic mul_step;
        logic add_step;
        logic diff_step;
        logic sq_step;
        logic acc_step;
        logic div_start;
        logic out_load;
    } pfm_cmd_t;

    typedef struct packed {
        logic terms_le1;
        logic step_last;
        logic last_item;
        logic div_done;
        logic out_free;
    } pfm_sts_t;

endpackage

[rtl/polynomial_fit_mse.sv]
// Top level: scores a configured polynomial against a stream of points by mean squared error.
//
//  channel  direction  beat contents
//  s_       in         tdata = x_value[15:0], y_value[31:16]; tlast = last_point
//  m_       out        tdata = mean_sq_error[47:0]; tuser = saturated
//  cfg_     in         cfg_index = register 0..7, cfg_data = value (term count in [2:0])
//
// A point is loaded, then runs one multiply and one add/saturate step on the shared 40x16
// Horner multiplier for each term after the first, then the difference, square and accumulate
// steps; a term count of zero takes the same path as one but with an estimate of zero.
// The last point of a set then starts the bit-serial 64-bit divider and loads the output.
// The result waits in the output register while the next point is taken.
// A stalled result only holds the block when a new mean is ready to be loaded.
// Reset is synchronous and active low; it restores coefficients to 0 and the term count to 1.
module polynomial_fit_mse #(
    parameter int MAX_TERMS  = pfm_pkg::DEF_MAX_TERMS,
    parameter int MAX_POINTS = pfm_pkg::DEF_MAX_POINTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfm_pkg::COEFF_W-1:0]    cfg_data,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pfm_pkg::S_DATA_W-1:0]   s_tdata,   // x_value[15:0], y_value[31:16]
    input  logic                           s_tlast,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pfm_pkg::OUT_W-1:0]      m_tdata,   // mean_sq_error[47:0]
    output logic                           m_tuser    // saturated[0]
);

    pfm_pkg::pfm_cmd_t cmd;
    pfm_pkg::pfm_sts_t sts;

    assign cfg_ready = 1'b1;

    pfm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pfm_dp #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_POINTS(MAX_POINTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/pfm_div.sv]
// Restoring divider, one quotient bit per cycle, for the error sum over the point count.
module pfm_div #(
    parameter int DVS_W = 17
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pfm_pkg::SUM_W-1:0]  dividend,
    input  logic [DVS_W-1:0]           divisor,
    output logic                       done,
    output logic [pfm_pkg::SUM_W-1:0]  quotient
);

    logic [pfm_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]              rem_reg, rem_next;
    logic [pfm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [DVS_W:0]                trial;
    logic [DVS_W:0]                trial_sub;
    logic                          fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[pfm_pkg::SUM_W-1]};
        trial_sub = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops safely
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[pfm_pkg::SUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pfm_pkg::DIV_CNT_W'(pfm_pkg::SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/pfm_dp.sv]
// Datapath: configuration registers, Horner evaluation, squared error, sums and output register.
module pfm_dp #(
    parameter int MAX_TERMS  = pfm_pkg::DEF_MAX_TERMS,
    parameter int MAX_POINTS = pfm_pkg::DEF_MAX_POINTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfm_pkg::COEFF_W-1:0]     cfg_data,
    input  logic [pfm_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tready,
    input  pfm_pkg::pfm_cmd_t               cmd,
    output pfm_pkg::pfm_sts_t               sts,
    output logic                            m_tvalid,
    output logic [pfm_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tuser
);

    localparam int STEP_W  = $clog2(MAX_TERMS + 1);
    localparam int IDX_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int COUNT_W = $clog2(MAX_POINTS + 1);
    localparam int EXT_W   = pfm_pkg::EST_W - pfm_pkg::COEFF_W;
    localparam int AEXT_W  = pfm_pkg::ADD_W - pfm_pkg::COEFF_W;
    localparam int YEXT_W  = pfm_pkg::DIFF_W - pfm_pkg::COEFF_W;
    localparam int HI_W    = pfm_pkg::ADD_W - pfm_pkg::EST_W + 1;

    localparam logic signed [pfm_pkg::EST_W-1:0] EST_MAX = {1'b0, {(pfm_pkg::EST_W-1){1'b1}}};
    localparam logic signed [pfm_pkg::EST_W-1:0] EST_MIN = {1'b1, {(pfm_pkg::EST_W-1){1'b0}}};

    // configuration
    logic signed [pfm_pkg::COEFF_W-1:0] coeff_reg [MAX_TERMS];
    logic [pfm_pkg::TC_W-1:0]           tc_reg;

    // per point
    logic signed [pfm_pkg::COEFF_W-1:0] x_reg, y_reg;
    logic                               last_reg;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic signed [pfm_pkg::EST_W-1:0]   est_reg, est_next;
    logic signed [pfm_pkg::PROD_W-1:0]  prod_reg;
    logic [pfm_pkg::DIFF_W-1:0]         mag_reg;
    logic [pfm_pkg::SUM_W-1:0]          sq_reg;

    // data set state
    logic [pfm_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [COUNT_W-1:0]                 count_reg, count_next;
    logic                               sat_reg, sat_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic [pfm_pkg::OUT_W-1:0]          out_data_reg;
    logic                               out_user_reg;

    logic [pfm_pkg::TC_W-1:0]           n_eff, n_m1;
    logic [STEP_W-1:0]                  step_m1;
    logic signed [pfm_pkg::COEFF_W-1:0] top_coeff, step_coeff;
    logic signed [pfm_pkg::ADD_W-1:0]   add_sum;
    logic [HI_W-1:0]                    add_hi;
    logic                               add_ovf;
    logic signed [pfm_pkg::DIFF_W-1:0]  diff;
    logic [pfm_pkg::DIFF_W-1:0]         mag_next;
    logic                               sq_big;
    logic [pfm_pkg::SQ_IN_W-1:0]        sq_lo;
    logic [pfm_pkg::SUM_W-1:0]          sq_prod;
    logic [pfm_pkg::SUM_W:0]            acc_sum;
    logic                               div_done;
    logic [pfm_pkg::SUM_W-1:0]          quotient;
    logic                               mean_ovf;

    pfm_div #(
        .DVS_W(COUNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(sum_reg),
        .divisor (count_reg),
        .done    (div_done),
        .quotient(quotient)
    );

    // configuration writes; coefficient indices at or above MAX_TERMS are never used, so drop them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TERMS; i++) begin
                coeff_reg[i] <= '0;
            end
            tc_reg <= pfm_pkg::TC_W'(1);
        end else if (cfg_valid) begin
            if (cfg_index == pfm_pkg::REG_TERM_COUNT) begin
                tc_reg <= cfg_data[pfm_pkg::TC_W-1:0];
            end else if (cfg_index < pfm_pkg::CFG_IDX_W'(MAX_TERMS)) begin
                coeff_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    // Horner set-up and step
    always_comb begin
        n_eff      = (tc_reg > pfm_pkg::TC_W'(MAX_TERMS)) ? pfm_pkg::TC_W'(MAX_TERMS) : tc_reg;
        n_m1       = n_eff - 1'b1;
        top_coeff  = coeff_reg[n_m1[IDX_W-1:0]];
        step_m1    = step_reg - 1'b1;
        step_coeff = coeff_reg[step_m1[IDX_W-1:0]];
        // floor the product by the fraction bits, keeping its sign
        add_sum    = {prod_reg[pfm_pkg::PROD_W-1],
                      prod_reg[pfm_pkg::PROD_W-1 -: (pfm_pkg::ADD_W - 1)]}
                     + {{AEXT_W{step_coeff[pfm_pkg::COEFF_W-1]}}, step_coeff};
        add_hi     = add_sum[pfm_pkg::ADD_W-1:pfm_pkg::EST_W-1];
        add_ovf    = !((add_hi == '0) || (add_hi == '1));
    end

    always_comb begin
        est_next  = est_reg;
        step_next = step_reg;
        if (cmd.load_item) begin
            if (n_eff == '0) begin
                est_next  = '0;
                step_next = '0;
            end else begin
                est_next  = {{EXT_W{top_coeff[pfm_pkg::COEFF_W-1]}}, top_coeff};
                step_next = n_m1[STEP_W-1:0];
            end
        end else if (cmd.add_step) begin
            step_next = step_m1;
            if (!add_ovf) begin
                est_next = add_sum[pfm_pkg::EST_W-1:0];
            end else if (add_sum[pfm_pkg::ADD_W-1]) begin
                est_next = EST_MIN;
            end else begin
                est_next = EST_MAX;
            end
        end
    end

    // squared error
    always_comb begin
        diff     = {est_reg[pfm_pkg::EST_W-1], est_reg}
                   - {{YEXT_W{y_reg[pfm_pkg::COEFF_W-1]}}, y_reg};
        mag_next = diff[pfm_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
        sq_big   = |mag_reg[pfm_pkg::DIFF_W-1:pfm_pkg::SQ_IN_W];
        sq_lo    = mag_reg[pfm_pkg::SQ_IN_W-1:0];
        sq_prod  = sq_lo * sq_lo;
        acc_sum  = {1'b0, sum_reg} + {1'b0, sq_reg};
    end

    always_comb begin
        mean_ovf = |quotient[pfm_pkg::SUM_W-1:pfm_pkg::OUT_W];
    end

    // data set state
    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        sat_next   = sat_reg;
        if (cmd.out_load) begin
            sum_next   = '0;
            count_next = '0;
            sat_next   = 1'b0;
        end else begin
            if (cmd.add_step && add_ovf) begin
                sat_next = 1'b1;
            end
            if (cmd.sq_step && sq_big) begin
                sat_next = 1'b1;
            end
            if (cmd.acc_step) begin
                if (acc_sum[pfm_pkg::SUM_W]) begin
                    sum_next = '1;
                    sat_next = 1'b1;
                end else begin
                    sum_next = acc_sum[pfm_pkg::SUM_W-1:0];
                end
                if (count_reg < COUNT_W'(MAX_POINTS)) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    sat_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            x_reg    <= s_tdata[pfm_pkg::COEFF_W-1:0];
            y_reg    <= s_tdata[pfm_pkg::S_DATA_W-1:pfm_pkg::COEFF_W];
            last_reg <= s_tlast;
        end
        est_reg  <= est_next;
        step_reg <= step_next;
        if (cmd.mul_step) begin
            prod_reg <= est_reg * x_reg;
        end
        if (cmd.diff_step) begin
            mag_reg <= mag_next;
        end
        if (cmd.sq_step) begin
            sq_reg <= sq_big ? '1 : sq_prod;
        end
        if (cmd.out_load) begin
            out_data_reg <= mean_ovf ? '1 : quotient[pfm_pkg::OUT_W-1:0];
            out_user_reg <= sat_reg | mean_ovf;
        end
    end

    always_comb begin
        sts.terms_le1 = (n_eff <= pfm_pkg::TC_W'(1));
        sts.step_last = (step_reg == STEP_W'(1));
        sts.last_item = last_reg;
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[rtl/pfm_ctrl.sv]
// Controller state machine that sequences the datapath for each point and for the mean at the end of a set.
module pfm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  pfm_pkg::pfm_sts_t  sts,
    output pfm_pkg::pfm_cmd_t  cmd
);

    pfm_pkg::pfm_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.terms_le1 ? pfm_pkg::ST_DIFF : pfm_pkg::ST_MUL;
                end
            end
            pfm_pkg::ST_MUL:    state_next = pfm_pkg::ST_ADD;
            pfm_pkg::ST_ADD:    state_next = sts.step_last ? pfm_pkg::ST_DIFF : pfm_pkg::ST_MUL;
            pfm_pkg::ST_DIFF:   state_next = pfm_pkg::ST_SQ;
            pfm_pkg::ST_SQ:     state_next = pfm_pkg::ST_ACC;
            pfm_pkg::ST_ACC:    state_next = sts.last_item ? pfm_pkg::ST_DIV_GO : pfm_pkg::ST_IDLE;
            pfm_pkg::ST_DIV_GO: state_next = pfm_pkg::ST_DIV;
            pfm_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = pfm_pkg::ST_OUT;
                end
            end
            pfm_pkg::ST_OUT: begin
                // hold the mean until the output register is free
                if (sts.out_free) begin
                    state_next = pfm_pkg::ST_IDLE;
                end
            end
            default:            state_next = pfm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_tready      = (state_reg == pfm_pkg::ST_IDLE);
        cmd.load_item = (state_reg == pfm_pkg::ST_IDLE) && s_tvalid;
        cmd.mul_step  = (state_reg == pfm_pkg::ST_MUL);
        cmd.add_step  = (state_reg == pfm_pkg::ST_ADD);
        cmd.diff_step = (state_reg == pfm_pkg::ST_DIFF);
        cmd.sq_step   = (state_reg == pfm_pkg::ST_SQ);
        cmd.acc_step  = (state_reg == pfm_pkg::ST_ACC);
        cmd.div_start = (state_reg == pfm_pkg::ST_DIV_GO);
        cmd.out_load  = (state_reg == pfm_pkg::ST_OUT) && sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
